@@ design/esc_pkg.sv @@
`timescale 1ns / 1ps
package esc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
  localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
  localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
  localparam logic [2:0] REG_CAL_MIXED   = 3'd3;
  localparam logic [2:0] REG_CAL_HUM     = 3'd4;

  // register stages of each unit
  localparam int LAT_TEMP  = 5;
  localparam int LAT_PREP  = 5;
  localparam int LAT_DIV   = 66;
  localparam int LAT_POST  = 5;
  localparam int LAT_HUM   = 9;
  localparam int LAT_TOTAL = LAT_TEMP + LAT_PREP + LAT_DIV + LAT_POST;

  localparam int DIV_W = 64;

  // unpacked calibration words, all raw bit fields
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } cal_t;

endpackage

@@ design/esc_delay.sv @@
`timescale 1ns / 1ps
module esc_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= din;
      for (int i = 1; i < D; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign dout = pipe[D-1];

endmodule

@@ design/esc_temp.sv @@
`timescale 1ns / 1ps
module esc_temp import esc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  cal_t               cal,
  input  logic [19:0]        temp_adc,
  output logic signed [31:0] tfine,
  output logic signed [31:0] temp
);

  logic signed [17:0] da, da_next;
  logic signed [16:0] d, d_next;
  logic signed [31:0] pa, dd;
  logic signed [33:0] pa_w, dd_w;
  logic signed [20:0] a3;
  logic signed [31:0] bb;
  logic signed [31:0] pa_sh, dd_sh, bb_sh;
  logic signed [47:0] bb_w;
  logic signed [31:0] tf4, tf4_next;
  logic signed [31:0] t5;

  always_comb begin
    da_next  = $signed({1'b0, temp_adc[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    d_next   = $signed({1'b0, temp_adc[19:4]}) - $signed({1'b0, cal.t1});
    pa_w     = da * $signed(cal.t2);
    dd_w     = d * d;
    pa_sh    = pa >>> 11;
    dd_sh    = dd >>> 12;
    bb_w     = dd_sh * $signed(cal.t3);
    bb_sh    = bb >>> 14;
    tf4_next = {{11{a3[20]}}, a3} + bb_sh;
    t5       = tf4 * 32'sd5 + 32'sd128;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da    <= da_next;
      d     <= d_next;
      pa    <= pa_w[31:0];
      dd    <= dd_w[31:0];
      a3    <= pa_sh[20:0];
      bb    <= bb_w[31:0];
      tf4   <= tf4_next;
      tfine <= tf4;
      temp  <= t5 >>> 8;
    end
  end

endmodule

@@ design/esc_pprep.sv @@
`timescale 1ns / 1ps
module esc_pprep import esc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  cal_t               cal,
  input  logic signed [31:0] tfine,
  input  logic [19:0]        press_adc,
  output logic [63:0]        dividend,
  output logic [63:0]        divisor
);

  logic signed [32:0] x1;
  logic signed [65:0] sq_w;
  logic signed [48:0] x1p5_w, x1p2_w;
  logic [63:0]        sq;
  logic signed [48:0] x1p5, x1p2, x1p5_2, x1p2_2;
  logic [20:0]        pp, pp2, pp3;
  logic signed [79:0] m6_w, m3_w;
  logic [63:0]        m6, m3;
  logic [63:0]        m3s, x2, x1b, x2_next, x1b_next;
  logic [63:0]        x1b_off;
  logic signed [80:0] x1m_w;
  logic [63:0]        x1m, e, e_next;
  logic signed [76:0] dvd_w;

  always_comb begin
    x1       = {tfine[31], tfine} - 33'sd128000;
    sq_w     = x1 * x1;
    x1p5_w   = x1 * $signed(cal.p5);
    x1p2_w   = x1 * $signed(cal.p2);
    m6_w     = $signed(sq) * $signed(cal.p6);
    m3_w     = $signed(sq) * $signed(cal.p3);
    m3s      = $signed(m3) >>> 8;
    x2_next  = m6 + ({{15{x1p5_2[48]}}, x1p5_2} << 17) + ({{48{cal.p4[15]}}, cal.p4} << 35);
    x1b_next = m3s + ({{15{x1p2_2[48]}}, x1p2_2} << 12);
    x1b_off  = x1b + 64'h0000_8000_0000_0000;
    x1m_w    = $signed(x1b_off) * $signed({1'b0, cal.p1});
    e_next   = {12'b0, pp3, 31'b0} - x2;
    dvd_w    = $signed(e) * 13'sd3125;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // P1
      sq     <= sq_w[63:0];
      x1p5   <= x1p5_w;
      x1p2   <= x1p2_w;
      pp     <= 21'd1048576 - {1'b0, press_adc};
      // P2
      m6     <= m6_w[63:0];
      m3     <= m3_w[63:0];
      x1p5_2 <= x1p5;
      x1p2_2 <= x1p2;
      pp2    <= pp;
      // P3
      x2     <= x2_next;
      x1b    <= x1b_next;
      pp3    <= pp2;
      // P4
      x1m    <= x1m_w[63:0];
      e      <= e_next;
      // P5
      divisor  <= $signed(x1m) >>> 33;
      dividend <= dvd_w[63:0];
    end
  end

endmodule

@@ design/esc_div.sv @@
`timescale 1ns / 1ps
module esc_div import esc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             div_zero
);

  typedef struct packed {
    logic [2*DIV_W-1:0] acc;   // partial remainder over remaining dividend/quotient bits
    logic [DIV_W-1:0]   den;
    logic               neg;
    logic               zero;
  } dstage_t;

  dstage_t st [DIV_W+1];
  dstage_t st0_next;

  always_comb begin
    st0_next.acc  = {{DIV_W{1'b0}}, dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend};
    st0_next.den  = divisor[DIV_W-1] ? (~divisor + 1'b1) : divisor;
    st0_next.neg  = dividend[DIV_W-1] ^ divisor[DIV_W-1];
    st0_next.zero = (divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar i = 0; i < DIV_W; i++) begin : g_step
    logic [DIV_W:0]   rem;
    logic [DIV_W:0]   diff;
    logic             qbit;
    dstage_t          nxt;
    always_comb begin
      rem  = st[i].acc[2*DIV_W-1:DIV_W-1];
      diff = rem - {1'b0, st[i].den};
      qbit = (rem >= {1'b0, st[i].den});
      nxt  = st[i];
      nxt.acc = {qbit ? diff[DIV_W-1:0] : rem[DIV_W-1:0], st[i].acc[DIV_W-2:0], qbit};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= st[DIV_W].neg ? (~st[DIV_W].acc[DIV_W-1:0] + 1'b1) : st[DIV_W].acc[DIV_W-1:0];
      div_zero <= st[DIV_W].zero;
    end
  end

endmodule

@@ design/esc_ppost.sv @@
`timescale 1ns / 1ps
module esc_ppost import esc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  cal_t        cal,
  input  logic [63:0] quotient,
  input  logic        div_zero,
  output logic [31:0] pressure,
  output logic        pressure_ok
);

  logic [63:0]        sh;
  logic [63:0]        lo_w, cr_w;
  logic signed [79:0] p8q_w, r1m_w;
  logic [63:0]        lo, q1, q2, q3;
  logic [31:0]        cr;
  logic [63:0]        p8q, p8q2, shsq, r1m, r2, s, s_sh, pv;
  logic [63:0]        r1;
  logic               z1, z2, z3, z4;

  always_comb begin
    sh    = $signed(quotient) >>> 13;
    lo_w  = sh[31:0] * sh[31:0];
    cr_w  = sh[31:0] * sh[63:32];
    p8q_w = $signed(quotient) * $signed(cal.p8);
    r1m_w = $signed(shsq) * $signed(cal.p9);
    r1    = $signed(r1m) >>> 25;
    // kept apart so the shift stays arithmetic
    s_sh  = $signed(s) >>> 8;
    pv    = s_sh + ({{48{cal.p7[15]}}, cal.p7} << 4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Q1: split square of the shifted quotient
      lo   <= lo_w;
      cr   <= cr_w[31:0];
      p8q  <= p8q_w[63:0];
      q1   <= quotient;
      z1   <= div_zero;
      // Q2: low 64 bits of the square, cross term counted twice
      shsq <= lo + {cr[30:0], 33'b0};
      p8q2 <= p8q;
      q2   <= q1;
      z2   <= z1;
      // Q3
      r1m  <= r1m_w[63:0];
      r2   <= $signed(p8q2) >>> 19;
      q3   <= q2;
      z3   <= z2;
      // Q4
      s    <= q3 + r1 + r2;
      z4   <= z3;
      // Q5
      pressure    <= z4 ? 32'd0 : pv[31:0];
      pressure_ok <= ~z4;
    end
  end

endmodule

@@ design/esc_hum.sv @@
`timescale 1ns / 1ps
module esc_hum import esc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  cal_t               cal,
  input  logic signed [31:0] tfine,
  input  logic [15:0]        hum_raw,
  output logic [16:0]        humidity
);

  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

  logic signed [31:0] v;
  logic signed [43:0] m1_w;
  logic signed [39:0] m2_w;
  logic signed [40:0] m3_w;
  logic signed [31:0] ha, m1, m2, m3;
  logic signed [31:0] t2, a2, b0, c;
  logic signed [63:0] bc_w;
  logic signed [31:0] bc, a3, t4;
  logic signed [47:0] b1_w;
  logic signed [31:0] b1, a4, b2, a5, t5;
  logic signed [63:0] v2_w;
  logic signed [31:0] v2, v2_7, v2_8, c2;
  logic signed [63:0] cc_w;
  logic signed [31:0] cc, cc_sh;
  logic signed [40:0] cch_w;
  logic signed [31:0] cch, v3;

  always_comb begin
    v     = tfine - 32'sd76800;
    m1_w  = $signed(cal.h5) * v;
    m2_w  = v * $signed(cal.h6);
    m3_w  = v * $signed({1'b0, cal.h3});
    t2    = ha - m1 + 32'sd16384;
    bc_w  = b0 * c;
    t4    = (bc >>> 10) + 32'sd2097152;
    b1_w  = t4 * $signed(cal.h2);
    t5    = b1 + 32'sd8192;
    v2_w  = a5 * b2;
    c2    = v2 >>> 15;
    cc_w  = c2 * c2;
    cc_sh = cc >>> 7;
    cch_w = cc_sh * $signed({1'b0, cal.h1});
    v3    = v2_8 - (cch >>> 4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // H1
      ha   <= $signed({2'b0, hum_raw, 14'b0}) - $signed({cal.h4, 20'b0});
      m1   <= m1_w[31:0];
      m2   <= m2_w[31:0];
      m3   <= m3_w[31:0];
      // H2
      a2   <= t2 >>> 15;
      b0   <= m2 >>> 10;
      c    <= (m3 >>> 11) + 32'sd32768;
      // H3
      bc   <= bc_w[31:0];
      a3   <= a2;
      // H4
      b1   <= b1_w[31:0];
      a4   <= a3;
      // H5
      b2   <= t5 >>> 14;
      a5   <= a4;
      // H6
      v2   <= v2_w[31:0];
      // H7
      cc   <= cc_w[31:0];
      v2_7 <= v2;
      // H8
      cch  <= cch_w[31:0];
      v2_8 <= v2_7;
      // H9: clamp to 0..100 percent
      if (v3 < 0) begin
        humidity <= '0;
      end else if (v3 > HUM_MAX) begin
        humidity <= HUM_MAX[28:12];
      end else begin
        humidity <= v3[28:12];
      end
    end
  end

endmodule

@@ design/env_sensor_compensation_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    temp_adc, press_adc, hum_raw
// out       out_valid / out_ready  temperature_centi, pressure_q24_8, pressure_valid,
//                                  humidity_q22_10
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. Sections in order:
// temperature, pressure prep, 64-bit divider at one quotient bit per stage,
// pressure finish; the 64-bit divider sets the depth. All stages advance
// together; a stalled output freezes the whole pipe and drops in_ready.
// Reset clears the valid chain and calibration registers. cfg_ready is always high.
module env_sensor_compensation_core import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        temp_adc,
  input  logic [19:0]        press_adc,
  input  logic [15:0]        hum_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_valid,
  output logic [16:0]        humidity_q22_10,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [47:0] cal_mixed;
  logic [31:0] cal_hum;
  cal_t        cal;

  logic                 en;
  logic [LAT_TOTAL-1:0] vld;

  logic signed [31:0] tfine, temp5;
  logic [19:0]        pr5;
  logic [15:0]        hr5;
  logic [63:0]        dividend, divisor, quotient;
  logic               div_zero;
  logic [16:0]        hum14;
  logic [31:0]        temp_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_mixed   <= '0;
      cal_hum     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAL_TEMP:    cal_temp    <= cfg_data[47:0];
        REG_CAL_PRESS_A: cal_press_a <= cfg_data;
        REG_CAL_PRESS_B: cal_press_b <= cfg_data;
        REG_CAL_MIXED:   cal_mixed   <= cfg_data[47:0];
        REG_CAL_HUM:     cal_hum     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = cal_temp[15:0];
    cal.t2 = cal_temp[31:16];
    cal.t3 = cal_temp[47:32];
    cal.p1 = cal_press_a[15:0];
    cal.p2 = cal_press_a[31:16];
    cal.p3 = cal_press_a[47:32];
    cal.p4 = cal_press_a[63:48];
    cal.p5 = cal_press_b[15:0];
    cal.p6 = cal_press_b[31:16];
    cal.p7 = cal_press_b[47:32];
    cal.p8 = cal_press_b[63:48];
    cal.p9 = cal_mixed[15:0];
    cal.h1 = cal_mixed[23:16];
    cal.h2 = cal_mixed[39:24];
    cal.h3 = cal_mixed[47:40];
    cal.h4 = cal_hum[11:0];
    cal.h5 = cal_hum[23:12];
    cal.h6 = cal_hum[31:24];
  end

  assign en        = ~vld[LAT_TOTAL-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT_TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT_TOTAL-2:0], in_valid};
    end
  end

  esc_temp u_temp (
    .clk      (clk),
    .en       (en),
    .cal      (cal),
    .temp_adc (temp_adc),
    .tfine    (tfine),
    .temp     (temp5)
  );

  esc_delay #(.W(20), .D(LAT_TEMP)) u_pr_dly (
    .clk (clk), .en (en), .din (press_adc), .dout (pr5)
  );

  esc_delay #(.W(16), .D(LAT_TEMP)) u_hr_dly (
    .clk (clk), .en (en), .din (hum_raw), .dout (hr5)
  );

  esc_pprep u_pprep (
    .clk       (clk),
    .en        (en),
    .cal       (cal),
    .tfine     (tfine),
    .press_adc (pr5),
    .dividend  (dividend),
    .divisor   (divisor)
  );

  esc_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .div_zero (div_zero)
  );

  esc_ppost u_ppost (
    .clk         (clk),
    .en          (en),
    .cal         (cal),
    .quotient    (quotient),
    .div_zero    (div_zero),
    .pressure    (pressure_q24_8),
    .pressure_ok (pressure_valid)
  );

  esc_hum u_hum (
    .clk      (clk),
    .en       (en),
    .cal      (cal),
    .tfine    (tfine),
    .hum_raw  (hr5),
    .humidity (hum14)
  );

  esc_delay #(.W(17), .D(LAT_TOTAL - LAT_TEMP - LAT_HUM)) u_hum_dly (
    .clk (clk), .en (en), .din (hum14), .dout (humidity_q22_10)
  );

  esc_delay #(.W(32), .D(LAT_TOTAL - LAT_TEMP)) u_temp_dly (
    .clk (clk), .en (en), .din (temp5), .dout (temp_out)
  );

  assign temperature_centi = temp_out;

  // a stalled pipe must hold every item in place
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid chain moved while stalled");

  a_press_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressure_valid |-> pressure_q24_8 == 32'd0)
    else $error("pressure nonzero with zero divisor");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

endmodule
